### rtl/core/spd_pkg.sv
`timescale 1ns / 1ps

package spd_pkg;

	// fixed field widths of the result and configuration
	localparam int INDEX_W    = 32;
	localparam int HEIGHT_W   = 16;
	localparam int THRESH_W   = 16;
	localparam int HW_FIELD_W = 7;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'b1;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// per-sample classification made by the front
	typedef struct packed {
		logic old_valid; // ring entry being replaced holds a real sample
		logic test;      // three-point test is armed for this sample
	} spd_flags_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_OUT
	} spd_state_t;

endpackage

### rtl/core/spd_ram.sv
`timescale 1ns / 1ps

module spd_ram
	import spd_pkg::*;
#(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/spd_front.sv
`timescale 1ns / 1ps

module spd_front
	import spd_pkg::*;
#(
	parameter int MAX_HALF_WINDOW = 64,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic [$clog2(MAX_HALF_WINDOW+1)-1:0] hw,
	input  logic [$clog2(MAX_HALF_WINDOW+1):0]   len,
	input  logic                               in_valid,
	input  logic                               full,
	output logic                               push,
	output logic [$clog2(2*MAX_HALF_WINDOW)-1:0] job_pos,
	output logic [INDEX_W-1:0]                 job_idx,
	output spd_flags_t                         job_flags
);

	localparam int LEN_W   = $clog2(MAX_HALF_WINDOW+1) + 1;
	localparam int RING_AW = $clog2(2*MAX_HALF_WINDOW);
	localparam int WARM_W  = $clog2(2*MAX_HALF_WINDOW+4);

	logic [RING_AW-1:0] pos_q;
	logic [INDEX_W-1:0] n_q;
	logic [WARM_W-1:0]  warm_q;
	logic [LEN_W-1:0]   pos_inc;
	logic [WARM_W-1:0]  warm_full;

	assign push      = in_valid && !full;
	assign pos_inc   = LEN_W'(pos_q) + LEN_W'(1);
	assign warm_full = WARM_W'(len) + WARM_W'(3);

	assign job_pos             = pos_q;
	assign job_idx             = n_q - INDEX_W'(hw);
	assign job_flags.old_valid = warm_q >= WARM_W'(len);
	assign job_flags.test      = warm_q >= warm_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			n_q    <= '0;
			warm_q <= '0;
		end else if (clear) begin
			pos_q  <= '0;
			n_q    <= '0;
			warm_q <= '0;
		end else if (push) begin
			pos_q <= (pos_inc >= len) ? '0 : RING_AW'(pos_inc);
			n_q   <= n_q + INDEX_W'(1);
			if (warm_q < warm_full) begin
				warm_q <= warm_q + WARM_W'(1);
			end
		end
	end

	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(pos_q) < len)
		else $error("ring position beyond window length");

endmodule

### rtl/core/spd_queue.sv
`timescale 1ns / 1ps

module spd_queue
	import spd_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	logic [WIDTH-1:0]  slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;

	assign full      = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < (QPTR_W+1)'(QUEUE_DEPTH) || pop))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

endmodule

### rtl/core/spd_back.sv
`timescale 1ns / 1ps

module spd_back
	import spd_pkg::*;
#(
	parameter int MAX_HALF_WINDOW = 64,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 clear,
	input  logic [$clog2(MAX_HALF_WINDOW+1):0]   len,
	input  logic [THRESH_W-1:0]                  thr,
	input  logic                                 job_valid,
	input  logic [SAMPLE_BITS-1:0]               job_sample,
	input  logic [$clog2(2*MAX_HALF_WINDOW)-1:0] job_pos,
	input  logic [INDEX_W-1:0]                   job_idx,
	input  spd_flags_t                           job_flags,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [INDEX_W-1:0]                   peak_index,
	output logic [HEIGHT_W-1:0]                  peak_height,
	output logic [INDEX_W-1:0]                   peak_gap
);

	localparam int LEN_W   = $clog2(MAX_HALF_WINDOW+1) + 1;
	localparam int RING_AW = $clog2(2*MAX_HALF_WINDOW);
	localparam int SUM_W   = SAMPLE_BITS + RING_AW;
	localparam int LIM_W   = THRESH_W + LEN_W;
	localparam int CMP_W   = (LIM_W > SUM_W) ? LIM_W : SUM_W;
	localparam int CNT_W   = $clog2(SUM_W);

	spd_state_t st_q, st_d;
	logic ram_re, do_calc, do_div, do_load;

	// job held for the current sample
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [RING_AW-1:0]     pos_q;
	logic [INDEX_W-1:0]     idx_q;
	spd_flags_t             flags_q;

	// stream state
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   pp_q;
	logic               seen_q;
	logic [INDEX_W-1:0] last_q;

	// peak being finished
	logic [INDEX_W-1:0] res_idx_q;
	logic [INDEX_W-1:0] res_gap_q;
	logic [SUM_W-1:0]   dq_q;
	logic [LEN_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;

	logic                   out_valid_q;
	logic [INDEX_W-1:0]     out_idx_q;
	logic [HEIGHT_W-1:0]    out_height_q;
	logic [INDEX_W-1:0]     out_gap_q;

	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic [SAMPLE_BITS-1:0] old_sample;
	logic [SUM_W-1:0]       s_new;
	logic signed [SUM_W:0]  d1;
	logic signed [SUM_W:0]  d2;
	logic [LIM_W-1:0]       limit;
	logic                   opposite;
	logic                   is_peak;
	logic [LEN_W:0]         trial;
	logic                   trial_ge;

	spd_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (2*MAX_HALF_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (do_calc),
		.waddr (pos_q),
		.wdata (sample_q),
		.re    (ram_re),
		.raddr (job_pos),
		.rdata (ram_rdata)
	);

	// running sum and three-point test
	assign old_sample = flags_q.old_valid ? ram_rdata : '0;
	assign s_new      = sum_q + SUM_W'(sample_q) - SUM_W'(old_sample);
	assign d1         = $signed({1'b0, sum_q}) - $signed({1'b0, pp_q});
	assign d2         = $signed({1'b0, s_new}) - $signed({1'b0, sum_q});
	assign limit      = LIM_W'(thr) * LIM_W'(len);
	assign opposite   = (d1 <= 0 && d2 >= 0) || (d1 >= 0 && d2 <= 0);
	assign is_peak    = flags_q.test && opposite && (d1 > d2)
		&& (CMP_W'(sum_q) > CMP_W'(limit));

	// restoring divide step, one quotient bit per cycle
	assign trial    = {rem_q, dq_q[SUM_W-1]};
	assign trial_ge = trial >= {1'b0, len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d    = st_q;
		pop     = 1'b0;
		ram_re  = 1'b0;
		do_calc = 1'b0;
		do_div  = 1'b0;
		do_load = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (job_valid) begin
					pop    = 1'b1;
					ram_re = 1'b1;
					st_d   = ST_CALC;
				end
			end
			ST_CALC: begin
				do_calc = 1'b1;
				st_d    = is_peak ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				do_div = 1'b1;
				if (cnt_q == '0) begin
					st_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					do_load = 1'b1;
					st_d    = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sample_q <= job_sample;
			pos_q    <= job_pos;
			idx_q    <= job_idx;
			flags_q  <= job_flags;
		end
		if (do_calc && is_peak) begin
			res_idx_q <= idx_q;
			res_gap_q <= seen_q ? (idx_q - last_q) : '0;
			dq_q      <= sum_q;
			rem_q     <= '0;
		end else if (do_div) begin
			rem_q <= trial_ge ? LEN_W'(trial - {1'b0, len}) : LEN_W'(trial);
			dq_q  <= {dq_q[SUM_W-2:0], trial_ge};
		end
		if (do_load) begin
			out_idx_q    <= res_idx_q;
			out_height_q <= HEIGHT_W'(dq_q);
			out_gap_q    <= res_gap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			pp_q        <= '0;
			seen_q      <= 1'b0;
			last_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clear) begin
				sum_q  <= '0;
				pp_q   <= '0;
				seen_q <= 1'b0;
				last_q <= '0;
			end else if (do_calc) begin
				pp_q  <= sum_q;
				sum_q <= s_new;
				if (is_peak) begin
					seen_q <= 1'b1;
					last_q <= idx_q;
				end
			end
			if (do_calc && is_peak) begin
				cnt_q <= CNT_W'(SUM_W-1);
			end else if (do_div) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (do_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign peak_index  = out_idx_q;
	assign peak_height = out_height_q;
	assign peak_gap    = out_gap_q;

	a_seen_drops_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(seen_q) |-> $past(clear))
		else $error("peak history lost without window change");

	a_mean_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT) |-> (dq_q[SUM_W-1:SAMPLE_BITS] == '0))
		else $error("window mean wider than a sample");

endmodule

### rtl/core/smoothed_peak_detector.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+----------------------------------
// input    | in        | in_valid / in_stall  | sample
// output   | out       | out_valid / out_stall| peak_index, peak_height, peak_gap
// config   | in        | cfg_we               | cfg_index, cfg_data
//
// in the back end a sample with no peak takes a ring read, then the sum update and
// ring write; a peak adds the bit-serial mean divider, then the output register load.
// the front takes one transaction per cycle, while the queue is not full, into a 4-entry job queue.
// reset clears all control and stream state; ring contents are masked by the
// warm-up count, so no clearing pass is needed.
// in_stall rises only when the job queue is full; out_stall holds the result register.
`timescale 1ns / 1ps

module smoothed_peak_detector
	import spd_pkg::*;
#(
	parameter int MAX_HALF_WINDOW = 64,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [INDEX_W-1:0]     peak_index,
	output logic [HEIGHT_W-1:0]    peak_height,
	output logic [INDEX_W-1:0]     peak_gap
);

	localparam int HW_W     = $clog2(MAX_HALF_WINDOW+1);
	localparam int LEN_W    = HW_W + 1;
	localparam int RING_AW  = $clog2(2*MAX_HALF_WINDOW);
	localparam int FLAGS_W  = $bits(spd_flags_t);
	localparam int JOB_W    = FLAGS_W + INDEX_W + RING_AW + SAMPLE_BITS;
	localparam int HW_RESET = (MAX_HALF_WINDOW < 10) ? MAX_HALF_WINDOW : 10;

	// configuration registers
	logic [HW_W-1:0]       hw_q;
	logic [THRESH_W-1:0]   thr_q;
	logic [HW_W-1:0]       hw_d;
	logic [HW_FIELD_W-1:0] hw_raw;
	logic [LEN_W-1:0]      len;
	logic                  clear;

	// front to queue
	logic                  push;
	logic                  full;
	logic [RING_AW-1:0]    f_pos;
	logic [INDEX_W-1:0]    f_idx;
	spd_flags_t            f_flags;
	logic [JOB_W-1:0]      push_data;

	// queue to back
	logic                  pop;
	logic                  not_empty;
	logic [JOB_W-1:0]      pop_data;
	logic [SAMPLE_BITS-1:0] b_sample;
	logic [RING_AW-1:0]    b_pos;
	logic [INDEX_W-1:0]    b_idx;
	spd_flags_t            b_flags;

	// half window: zero acts as one, oversize clamps to MAX_HALF_WINDOW so the window fits the ring
	assign hw_raw = cfg_data[HW_FIELD_W-1:0];
	always_comb begin
		if (hw_raw == '0) begin
			hw_d = HW_W'(1);
		end else if (int'(hw_raw) > MAX_HALF_WINDOW) begin
			hw_d = HW_W'(MAX_HALF_WINDOW);
		end else begin
			hw_d = HW_W'(hw_raw);
		end
	end

	// a new half window restarts the stream; a new threshold clears nothing
	assign clear = cfg_we && (cfg_index == REG_HALF_WINDOW);
	assign len   = {hw_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q  <= HW_W'(HW_RESET);
			thr_q <= THRESH_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF_WINDOW: hw_q  <= hw_d;
				REG_THRESHOLD:   thr_q <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = full;

	spd_front #(
		.MAX_HALF_WINDOW (MAX_HALF_WINDOW),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (clear),
		.hw        (hw_q),
		.len       (len),
		.in_valid  (in_valid),
		.full      (full),
		.push      (push),
		.job_pos   (f_pos),
		.job_idx   (f_idx),
		.job_flags (f_flags)
	);

	assign push_data = {f_flags, f_idx, f_pos, sample};

	spd_queue #(
		.WIDTH (JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	assign {b_flags, b_idx, b_pos, b_sample} = pop_data;

	spd_back #(
		.MAX_HALF_WINDOW (MAX_HALF_WINDOW),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (clear),
		.len         (len),
		.thr         (thr_q),
		.job_valid   (not_empty),
		.job_sample  (b_sample),
		.job_pos     (b_pos),
		.job_idx     (b_idx),
		.job_flags   (b_flags),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.peak_index  (peak_index),
		.peak_height (peak_height),
		.peak_gap    (peak_gap)
	);

endmodule
